/* rtl/assert_macros.svh */
// Assertion macros used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_CLK_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`else

`define ASSERT_CLK_RST(label, clk, rst_n, prop)

`define ASSERT_CLK(label, clk, prop)

`endif

`endif

/* rtl/kscd_pkg.sv */
package kscd_pkg;

    localparam logic [7:0] SPACE_BYTE  = 8'd32;
    localparam logic [7:0] LETTER_BASE = 8'd97;

    localparam logic FUNC_KEY = 1'b0;
    localparam logic FUNC_MSG = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic scan_step;
        logic append;
        logic mark_hit;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic is_msg;
        logic is_space;
        logic full;
        logic scan_done;
        logic match;
        logic out_free;
    } status_t;

endpackage

/* rtl/kscd_ram.sv */
module kscd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 26,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  logic [WIDTH-1:0]      wr_data,
    input  logic [ADDR_W-1:0]     rd_addr,
    output logic [WIDTH-1:0]      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/kscd_ctrl.sv */
module kscd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  kscd_pkg::status_t status,
    output kscd_pkg::cmd_t    cmd
);

    kscd_pkg::state_t state_reg;
    kscd_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= kscd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            kscd_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = kscd_pkg::ST_READ;
                end
            end
            kscd_pkg::ST_READ: begin
                if (!status.is_msg && (status.is_space || status.full)) begin
                    state_next = kscd_pkg::ST_IDLE;
                end else if (status.scan_done) begin
                    if (status.is_msg) begin
                        state_next = kscd_pkg::ST_EMIT;
                    end else begin
                        cmd.append = 1'b1;
                        state_next = kscd_pkg::ST_IDLE;
                    end
                end else begin
                    state_next = kscd_pkg::ST_CMP;
                end
            end
            kscd_pkg::ST_CMP: begin
                if (status.match) begin
                    if (status.is_msg) begin
                        cmd.mark_hit = 1'b1;
                        state_next   = kscd_pkg::ST_EMIT;
                    end else begin
                        state_next = kscd_pkg::ST_IDLE;
                    end
                end else begin
                    cmd.scan_step = 1'b1;
                    state_next    = kscd_pkg::ST_READ;
                end
            end
            kscd_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = kscd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = kscd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/kscd_datapath.sv */
module kscd_datapath #(
    parameter int ALPHABET_SIZE = 26
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [7:0]        s_tdata,
    input  logic              s_tuser,
    output logic [7:0]        m_tdata,
    output logic              m_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  kscd_pkg::cmd_t    cmd,
    output kscd_pkg::status_t status
);

    localparam int IDX_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int CNT_W = $clog2(ALPHABET_SIZE + 1);

    logic             func_reg;
    logic [7:0]       byte_reg;
    logic [CNT_W-1:0] scan_idx_reg;
    logic [CNT_W-1:0] fill_count_reg;
    logic             hit_reg;
    logic [7:0]       m_tdata_reg;
    logic             m_tuser_reg;
    logic             m_tvalid_reg;
    logic [7:0]       rd_data;

    kscd_ram #(
        .WIDTH (8),
        .DEPTH (ALPHABET_SIZE)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (cmd.append),
        .wr_addr (fill_count_reg[IDX_W-1:0]),
        .wr_data (byte_reg),
        .rd_addr (scan_idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg <= s_tuser;
            byte_reg <= s_tdata;
        end
        if (cmd.capture) begin
            scan_idx_reg <= '0;
        end else if (cmd.scan_step) begin
            scan_idx_reg <= scan_idx_reg + CNT_W'(1);
        end
        if (cmd.capture) begin
            hit_reg <= 1'b0;
        end else if (cmd.mark_hit) begin
            hit_reg <= 1'b1;
        end
        if (cmd.out_load) begin
            m_tdata_reg <= hit_reg ? 8'(kscd_pkg::LETTER_BASE + 8'(scan_idx_reg))
                                   : kscd_pkg::SPACE_BYTE;
            m_tuser_reg <= hit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_count_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cmd.append) begin
                fill_count_reg <= fill_count_reg + CNT_W'(1);
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        status.is_msg    = (func_reg == kscd_pkg::FUNC_MSG);
        status.is_space  = (byte_reg == kscd_pkg::SPACE_BYTE);
        status.full      = (fill_count_reg == CNT_W'(ALPHABET_SIZE));
        status.scan_done = (scan_idx_reg == fill_count_reg);
        status.match     = (rd_data == byte_reg);
        status.out_free  = !m_tvalid_reg || m_tready;
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule

/* rtl/keyword_substitution_decoder_core.sv */
// Keyword substitution decoder.
// Slave channel: s_tdata carries the character byte, s_tuser says what it is
// (0: key byte, 1: message byte). Master channel: m_tdata carries the decoded
// byte, m_tuser is high when the message byte was found in the alphabet.
// A key byte extends the alphabet unless it is a space, already present or
// the alphabet is full; it returns no transaction. Each message byte returns
// exactly one transaction: 'a' plus the index of the match, or a space.
// One item is handled at a time. The alphabet sits in a single-port-read
// RAM that is searched one entry at a time (address, then compare), up to
// a match or the end of the filled part. A message result is loaded into
// the output register once its search ends and that register is free, and
// shows on the master side from the next cycle. A finished result waits
// in the output register, and the next item is taken meanwhile; only a second
// result waits for that register to free.
// Reset empties the alphabet and drops any pending result; no clearing pass.
module keyword_substitution_decoder_core #(
    parameter int ALPHABET_SIZE = 26
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tuser,   // [0] func
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] plain_byte
    output logic       m_tuser    // [0] found
);

`include "assert_macros.svh"

    kscd_pkg::cmd_t    cmd;
    kscd_pkg::status_t status;

    kscd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    kscd_datapath #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    `ASSERT_CLK_RST(a_busy_after_accept, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready)
    `ASSERT_CLK_RST(a_append_legal, aclk, aresetn, cmd.append |-> !status.full && !status.is_space && !status.is_msg)
    `ASSERT_CLK_RST(a_no_overwrite, aclk, aresetn, cmd.out_load |-> (!m_tvalid || m_tready))
    `ASSERT_CLK_RST(a_load_shows, aclk, aresetn, cmd.out_load |=> m_tvalid)

endmodule

/* dv/tb_keyword_substitution_decoder_core.sv */
`timescale 1ns / 1ps

module tb_keyword_substitution_decoder_core;

    localparam int ALPHABET_SIZE = 26;
    localparam int TARGET_CHARS  = 1300;
    localparam int SETTLE_CYCLES = 2 * ALPHABET_SIZE + 20;
    localparam int CYCLE_LIMIT   = 500000;

    typedef struct {
        logic       func;
        logic [7:0] data_byte;
        logic       drain;
    } char_item_t;

    typedef struct {
        logic [7:0] plain_byte;
        logic       found;
    } plain_t;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tuser;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tuser;

    char_item_t pending_chars[$];
    plain_t     expected_plain[$];

    // predictor state
    logic [7:0] alpha_tbl[ALPHABET_SIZE];
    int         alpha_fill;

    // stimulus shadow, used only to steer the generator
    bit         gen_seen[256];
    logic [7:0] key_list[$];
    int         counted_chars;

    int         mismatch_cnt;
    int         cycle_cnt;
    int         burst_left;
    int         gap_left;
    int         ready_left;
    int         stall_left;
    char_item_t next_char;

    keyword_substitution_decoder_core #(
        .ALPHABET_SIZE(ALPHABET_SIZE)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    task automatic apply_char(input logic func, input logic [7:0] b);
        int     k;
        int     hit_idx;
        plain_t res;
        hit_idx = -1;
        for (k = 0; k < alpha_fill; k++) begin
            if (hit_idx < 0 && alpha_tbl[k] == b) begin
                hit_idx = k;
            end
        end
        if (func == kscd_pkg::FUNC_KEY) begin
            if (b != kscd_pkg::SPACE_BYTE && alpha_fill < ALPHABET_SIZE && hit_idx < 0) begin
                alpha_tbl[alpha_fill] = b;
                alpha_fill++;
            end
        end else begin
            if (hit_idx >= 0) begin
                res.plain_byte = kscd_pkg::LETTER_BASE + 8'(hit_idx);
                res.found      = 1'b1;
            end else begin
                res.plain_byte = kscd_pkg::SPACE_BYTE;
                res.found      = 1'b0;
            end
            expected_plain.push_back(res);
        end
    endtask

    task automatic push_char(input logic func, input logic [7:0] b);
        char_item_t it;
        it.func      = func;
        it.data_byte = b;
        it.drain     = 1'b0;
        pending_chars.push_back(it);
        if (func == kscd_pkg::FUNC_MSG) begin
            counted_chars++;
        end else if (b != kscd_pkg::SPACE_BYTE && key_list.size() < ALPHABET_SIZE
                     && !gen_seen[b]) begin
            gen_seen[b] = 1'b1;
            key_list.push_back(b);
            counted_chars++;
        end
    endtask

    task automatic push_drain();
        char_item_t it;
        it.func      = kscd_pkg::FUNC_KEY;
        it.data_byte = 8'h00;
        it.drain     = 1'b1;
        pending_chars.push_back(it);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= 8'h00;
            s_tuser    <= kscd_pkg::FUNC_KEY;
            burst_left <= $urandom_range(1, 16);
            gap_left   <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_char(s_tuser, s_tdata);
            end
            if (s_tvalid && !s_tready) begin
                // hold the current transaction
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending_chars.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (pending_chars[0].drain) begin
                if (expected_plain.size() == 0) begin
                    void'(pending_chars.pop_front());
                end
                s_tvalid <= 1'b0;
            end else begin
                next_char = pending_chars.pop_front();
                s_tvalid  <= 1'b1;
                s_tdata   <= next_char.data_byte;
                s_tuser   <= next_char.func;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 16);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            ready_left <= $urandom_range(1, 12);
            stall_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_plain.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("unexpected transaction: plain_byte=%0d found=%0b",
                                 m_tdata, m_tuser);
                    end
                end else begin
                    plain_t exp_res;
                    exp_res = expected_plain.pop_front();
                    if (m_tdata !== exp_res.plain_byte || m_tuser !== exp_res.found) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("mismatch: expected plain_byte=%0d found=%0b, got %0d %0b",
                                     exp_res.plain_byte, exp_res.found, m_tdata, m_tuser);
                        end
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (ready_left <= 1) begin
                    ready_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                             : $urandom_range(1, 12);
                    stall_left <= $urandom_range(0, 9);
                end else begin
                    ready_left <= ready_left - 1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int         n;
        logic       is_key;
        logic [7:0] b;
        int         r;

        aresetn       = 1'b0;
        counted_chars = 0;

        // message before any key, then key and message corner cases
        push_char(kscd_pkg::FUNC_MSG, 8'd97);
        push_char(kscd_pkg::FUNC_KEY, kscd_pkg::SPACE_BYTE);
        push_char(kscd_pkg::FUNC_KEY, 8'h00);
        push_char(kscd_pkg::FUNC_KEY, 8'hFF);
        push_char(kscd_pkg::FUNC_KEY, 8'd107);
        push_char(kscd_pkg::FUNC_KEY, 8'd101);
        push_char(kscd_pkg::FUNC_KEY, 8'd121);
        push_char(kscd_pkg::FUNC_KEY, 8'd107);
        push_char(kscd_pkg::FUNC_KEY, 8'h00);
        push_char(kscd_pkg::FUNC_MSG, 8'h00);
        push_char(kscd_pkg::FUNC_MSG, 8'hFF);
        push_char(kscd_pkg::FUNC_MSG, 8'd121);
        push_char(kscd_pkg::FUNC_MSG, kscd_pkg::SPACE_BYTE);
        push_char(kscd_pkg::FUNC_MSG, 8'd122);
        push_char(kscd_pkg::FUNC_MSG, 8'd107);
        push_char(kscd_pkg::FUNC_MSG, 8'h80);
        push_char(kscd_pkg::FUNC_MSG, 8'h7F);
        push_drain();

        n = 0;
        while (counted_chars < TARGET_CHARS) begin
            n++;
            if (n % 250 == 0) begin
                push_drain();
            end
            if (key_list.size() < ALPHABET_SIZE) begin
                is_key = ($urandom_range(0, 9) < 6);
            end else begin
                is_key = ($urandom_range(0, 19) == 0);
            end
            if (is_key) begin
                r = $urandom_range(0, 9);
                if (r == 0) begin
                    b = kscd_pkg::SPACE_BYTE;
                end else if (r == 1 && key_list.size() > 0) begin
                    b = key_list[$urandom_range(0, key_list.size() - 1)];
                end else begin
                    b = 8'($urandom_range(0, 255));
                end
                push_char(kscd_pkg::FUNC_KEY, b);
            end else begin
                r = $urandom_range(0, 19);
                if (r < 12 && key_list.size() > 0) begin
                    b = key_list[$urandom_range(0, key_list.size() - 1)];
                end else if (r < 14) begin
                    b = kscd_pkg::SPACE_BYTE;
                end else begin
                    b = 8'($urandom_range(0, 255));
                end
                push_char(kscd_pkg::FUNC_MSG, b);
            end
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_chars.size() != 0 || s_tvalid || expected_plain.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_cnt == 0 && expected_plain.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
